/* src/mshe_pkg.sv */
package mshe_pkg;

   typedef struct packed {
      logic [3:0]  mode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // classified item: marker byte, value bytes left aligned, value byte count
   typedef struct packed {
      logic [7:0]  marker;
      logic [63:0] data;
      logic [3:0]  nbytes;
   } work_type;

   // queue push side
   typedef struct packed {
      logic     push;
      work_type work;
   } qwr_type;

   // queue pop side
   typedef struct packed {
      logic     valid;
      work_type work;
   } qrd_type;

   localparam logic [3:0] MODE_NIL   = 4'd0;
   localparam logic [3:0] MODE_BOOL  = 4'd1;
   localparam logic [3:0] MODE_UINT  = 4'd2;
   localparam logic [3:0] MODE_SINT  = 4'd3;
   localparam logic [3:0] MODE_F32   = 4'd4;
   localparam logic [3:0] MODE_STR   = 4'd5;
   localparam logic [3:0] MODE_BIN   = 4'd6;
   localparam logic [3:0] MODE_ARRAY = 4'd7;
   localparam logic [3:0] MODE_MAP   = 4'd8;
   localparam logic [3:0] MODE_RAW   = 4'd9;

   localparam logic [7:0] MK_NIL     = 8'hC0;
   localparam logic [7:0] MK_FALSE   = 8'hC2;
   localparam logic [7:0] MK_TRUE    = 8'hC3;
   localparam logic [7:0] MK_BIN8    = 8'hC4;
   localparam logic [7:0] MK_BIN16   = 8'hC5;
   localparam logic [7:0] MK_BIN32   = 8'hC6;
   localparam logic [7:0] MK_F32     = 8'hCA;
   localparam logic [7:0] MK_U8      = 8'hCC;
   localparam logic [7:0] MK_U16     = 8'hCD;
   localparam logic [7:0] MK_U32     = 8'hCE;
   localparam logic [7:0] MK_U64     = 8'hCF;
   localparam logic [7:0] MK_I8      = 8'hD0;
   localparam logic [7:0] MK_I16     = 8'hD1;
   localparam logic [7:0] MK_I32     = 8'hD2;
   localparam logic [7:0] MK_I64     = 8'hD3;
   localparam logic [7:0] MK_STR8    = 8'hD9;
   localparam logic [7:0] MK_STR16   = 8'hDA;
   localparam logic [7:0] MK_STR32   = 8'hDB;
   localparam logic [7:0] MK_ARR16   = 8'hDC;
   localparam logic [7:0] MK_ARR32   = 8'hDD;
   localparam logic [7:0] MK_MAP16   = 8'hDE;
   localparam logic [7:0] MK_MAP32   = 8'hDF;
   localparam logic [7:0] MK_FIXSTR  = 8'hA0;
   localparam logic [7:0] MK_FIXARR  = 8'h90;
   localparam logic [7:0] MK_FIXMAP  = 8'h80;

   localparam logic [3:0] MAX_ITEM_BYTES = 4'd9;

endpackage

/* src/msgpack_scalar_header_encoder_unit.sv */
// MessagePack scalar and header encoder.
// req channel: one transfer per item (mode, 64-bit value). Modes 10 to 15 are
// accepted and produce nothing.
// rsp channel: one transfer per encoded byte, marker first, value bytes
// big-endian, last_byte set on the final byte of an item (1 to 9 bytes).
// A front stage classifies the item in the accept cycle and writes it into a
// small queue (QUEUE_DEPTH entries); a back stage shifts it out one byte per
// cycle, while rsp_stall is low, into the rsp output register.
// From an empty block, the first byte of an item passes the queue entry, the
// serializer shift register and then the rsp output register.
// Throughput: one rsp byte per cycle while rsp_stall is low; successive items
// follow back to back. The serializer sets this rate.
// req_stall rises only when the queue is full.
// A stalled rsp byte holds; a busy serializer and the queue hold behind it.
// Reset (synchronous, active high) empties the queue and drops any item in
// flight; no clearing pass is needed.
module msgpack_scalar_header_encoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mshe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mshe_pkg::rsp_type rsp_data
);
   import mshe_pkg::*;

   qwr_type q_wr;
   qrd_type q_rd;
   logic    q_full;
   logic    q_pop;

   mshe_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .q_wr      (q_wr)
   );

   mshe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (q_full),
      .q_rd  (q_rd)
   );

   mshe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rd      (q_rd),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/mshe_front.sv */
module mshe_front (
   input  logic             req_valid,
   input  mshe_pkg::req_type req_data,
   input  logic             q_full,
   output logic             req_stall,
   output mshe_pkg::qwr_type q_wr
);
   import mshe_pkg::*;

   logic [63:0] v;
   logic [31:0] hlen;
   logic        mode_ok;
   logic [7:0]  marker;
   logic [3:0]  nbytes;
   logic [63:0] src;
   logic [63:0] aligned;
   logic        s_fix, s8, s16, s32;

   assign v = req_data.value;
   // header lengths saturate at 32 bits
   assign hlen = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];

   assign s_fix = (v[63:7] == 57'd0) || (&v[63:5]);
   assign s8    = (v[63:7] == 57'd0) || (&v[63:7]);
   assign s16   = (v[63:15] == 49'd0) || (&v[63:15]);
   assign s32   = (v[63:31] == 33'd0) || (&v[63:31]);

   always_comb begin
      mode_ok = 1'b1;
      marker  = MK_NIL;
      nbytes  = 4'd0;
      src     = v;
      case (req_data.mode)
         MODE_NIL: begin
            marker = MK_NIL;
         end
         MODE_BOOL: begin
            marker = (v != 64'd0) ? MK_TRUE : MK_FALSE;
         end
         MODE_UINT: begin
            if (v[63:7] == 57'd0) begin
               marker = v[7:0];
            end else if (v[63:8] == 56'd0) begin
               marker = MK_U8;
               nbytes = 4'd1;
            end else if (v[63:16] == 48'd0) begin
               marker = MK_U16;
               nbytes = 4'd2;
            end else if (v[63:32] == 32'd0) begin
               marker = MK_U32;
               nbytes = 4'd4;
            end else begin
               marker = MK_U64;
               nbytes = 4'd8;
            end
         end
         MODE_SINT: begin
            if (s_fix) begin
               marker = v[7:0];
            end else if (s8) begin
               marker = MK_I8;
               nbytes = 4'd1;
            end else if (s16) begin
               marker = MK_I16;
               nbytes = 4'd2;
            end else if (s32) begin
               marker = MK_I32;
               nbytes = 4'd4;
            end else begin
               marker = MK_I64;
               nbytes = 4'd8;
            end
         end
         MODE_F32: begin
            marker = MK_F32;
            nbytes = 4'd4;
         end
         MODE_STR: begin
            src = {32'd0, hlen};
            if (hlen <= 32'd31) begin
               marker = MK_FIXSTR + {3'd0, hlen[4:0]};
            end else if (hlen <= 32'hFF) begin
               marker = MK_STR8;
               nbytes = 4'd1;
            end else if (hlen <= 32'hFFFF) begin
               marker = MK_STR16;
               nbytes = 4'd2;
            end else begin
               marker = MK_STR32;
               nbytes = 4'd4;
            end
         end
         MODE_BIN: begin
            src = {32'd0, hlen};
            if (hlen <= 32'hFF) begin
               marker = MK_BIN8;
               nbytes = 4'd1;
            end else if (hlen <= 32'hFFFF) begin
               marker = MK_BIN16;
               nbytes = 4'd2;
            end else begin
               marker = MK_BIN32;
               nbytes = 4'd4;
            end
         end
         MODE_ARRAY: begin
            src = {32'd0, hlen};
            if (hlen <= 32'd15) begin
               marker = MK_FIXARR + {4'd0, hlen[3:0]};
            end else if (hlen <= 32'hFFFF) begin
               marker = MK_ARR16;
               nbytes = 4'd2;
            end else begin
               marker = MK_ARR32;
               nbytes = 4'd4;
            end
         end
         MODE_MAP: begin
            src = {32'd0, hlen};
            if (hlen <= 32'd15) begin
               marker = MK_FIXMAP + {4'd0, hlen[3:0]};
            end else if (hlen <= 32'hFFFF) begin
               marker = MK_MAP16;
               nbytes = 4'd2;
            end else begin
               marker = MK_MAP32;
               nbytes = 4'd4;
            end
         end
         MODE_RAW: begin
            marker = v[7:0];
         end
         default: begin
            mode_ok = 1'b0;
         end
      endcase
   end

   // left align the low value bytes so the back end just shifts out the top byte
   always_comb begin
      case (nbytes)
         4'd1:    aligned = {src[7:0], 56'd0};
         4'd2:    aligned = {src[15:0], 48'd0};
         4'd4:    aligned = {src[31:0], 32'd0};
         4'd8:    aligned = src;
         default: aligned = 64'd0;
      endcase
   end

   assign req_stall       = q_full;
   // unused modes are taken and dropped
   assign q_wr.push       = req_valid && !q_full && mode_ok;
   assign q_wr.work.marker = marker;
   assign q_wr.work.data   = aligned;
   assign q_wr.work.nbytes = nbytes;

endmodule

/* src/mshe_queue.sv */
module mshe_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  mshe_pkg::qwr_type q_wr,
   input  logic              pop,
   output logic              full,
   output mshe_pkg::qrd_type q_rd
);
   import mshe_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   work_type        entry_ff [DEPTH];
   logic [IW-1:0]   wptr_ff, wptr_in;
   logic [IW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.work  = entry_ff[rptr_ff];
   assign do_pop     = pop && q_rd.valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (q_wr.push) begin
         wptr_in = (wptr_ff == LAST_IDX) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LAST_IDX) ? '0 : rptr_ff + 1'b1;
      end
      case ({q_wr.push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         entry_ff[wptr_ff] <= q_wr.work;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !full)
      else $error("queue push while full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count out of range");

endmodule

/* src/mshe_back.sv */
module mshe_back (
   input  logic              clock,
   input  logic              reset,
   input  mshe_pkg::qrd_type q_rd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mshe_pkg::rsp_type rsp_data
);
   import mshe_pkg::*;

   logic        active_ff, active_in;
   logic [71:0] shift_ff, shift_in;
   logic [3:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        advance;
   logic        emit;
   logic        finishing;

   // output register frees up when empty or taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = active_ff && advance;
   assign finishing = emit && (count_ff == 4'd1);
   assign pop       = q_rd.valid && (!active_ff || finishing);

   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = active_ff;
      end
      if (emit) begin
         rsp_data_in.out_byte  = shift_ff[71:64];
         rsp_data_in.last_byte = (count_ff == 4'd1);
         shift_in = {shift_ff[63:0], 8'd0};
         count_in = count_ff - 4'd1;
      end
      if (pop) begin
         active_in = 1'b1;
         shift_in  = {q_rd.work.marker, q_rd.work.data};
         count_in  = q_rd.work.nbytes + 4'd1;
      end else if (finishing) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 4'd0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (count_ff != 4'd0) && (count_ff <= MAX_ITEM_BYTES))
      else $error("active item with bad byte count");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (finishing && !q_rd.valid) |=> !active_ff)
      else $error("serializer stayed busy after final byte");

endmodule
